@@ design/lhba_pkg.sv @@
package lhba_pkg;

   localparam int BUCKETS_PER_SEGMENT = 32;
   localparam int MAX_BUCKETS = 65536;
   localparam int QUEUE_DEPTH = 4;

   localparam logic [20:0] HASH_MOD = 21'd1048583;
   localparam logic [19:0] COUNT_MAX = 20'hFFFFF;
   localparam logic [11:0] SEG_MAX = 12'hFFF;

   // Residues of 2^20, 2^40 and 2^60 modulo the hash prime are -7, 49 and -343.
   localparam logic [26:0] RES_20 = 27'd7;
   localparam logic [26:0] RES_40 = 27'd49;
   localparam logic [26:0] RES_60 = 27'd343;

   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
   localparam logic [7:0] CASE_OFFSET = 8'h20;

   typedef enum logic [1:0] {
      CMD_BYTE   = 2'd0,
      CMD_INSERT = 2'd1,
      CMD_REMOVE = 2'd2
   } cmd_type;

   typedef struct packed {
      logic        is_key;
      logic [15:0] tmask;
      logic [14:0] sp;
      logic        split_now;
      logic [14:0] split_from;
      logic [15:0] split_to;
      logic [15:0] split_mask;
      logic [19:0] key_count;
   } ctl_type;

   typedef struct packed {
      ctl_type     ctl;
      logic [63:0] hash;
   } entry_type;

   typedef struct packed {
      logic empty;
      logic full;
   } qstat_type;

endpackage

@@ design/lhba_front.sv @@
module lhba_front import lhba_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic [1:0]  req_command,
   input  logic [7:0]  req_key_byte,
   input  logic        req_last,
   output logic        req_stall,
   input  qstat_type   q_stat,
   output logic        push,
   output entry_type   push_entry
);

   logic [63:0] hash_ff, hash_in;
   logic        ended_ff, ended_in;
   logic [14:0] sp_ff, sp_in;
   logic [16:0] tsize_ff, tsize_in;
   logic [19:0] keys_ff, keys_in;
   logic [11:0] segs_ff, segs_in;

   logic        accept;
   logic [7:0]  upper;
   logic [63:0] hashed;
   logic [63:0] key_hash;
   logic [19:0] keys_inc;
   logic [16:0] new_addr;
   logic [16:0] sp_plus;
   logic        grow;

   assign req_stall = q_stat.full;
   assign accept = req_valid && !req_stall;

   always_comb begin
      upper = req_key_byte;
      if (req_key_byte >= CHAR_LOWER_A && req_key_byte <= CHAR_LOWER_Z) begin
         upper = req_key_byte - CASE_OFFSET;
      end
      hashed = ((hash_ff << 5) + (hash_ff << 2) + hash_ff) ^ 64'(upper);
      key_hash = (req_key_byte == 8'd0 || ended_ff) ? hash_ff : hashed;
      keys_inc = (keys_ff < COUNT_MAX) ? keys_ff + 20'd1 : keys_ff;
      new_addr = tsize_ff + 17'(sp_ff);
      sp_plus = 17'(sp_ff) + 17'd1;
      grow = (32'(keys_inc) >= 32'(segs_ff) * BUCKETS_PER_SEGMENT) &&
             (32'(new_addr) < MAX_BUCKETS);
   end

   always_comb begin
      hash_in = hash_ff;
      ended_in = ended_ff;
      sp_in = sp_ff;
      tsize_in = tsize_ff;
      keys_in = keys_ff;
      segs_in = segs_ff;
      push = 1'b0;
      push_entry = '0;
      if (accept) begin
         case (cmd_type'(req_command))
            CMD_BYTE: begin
               if (req_key_byte == 8'd0) begin
                  ended_in = 1'b1;
               end else if (!ended_ff) begin
                  hash_in = hashed;
               end
               if (req_last) begin
                  push = 1'b1;
                  push_entry.hash = key_hash;
                  push_entry.ctl.is_key = 1'b1;
                  push_entry.ctl.tmask = 16'(tsize_ff - 17'd1);
                  push_entry.ctl.sp = sp_ff;
                  push_entry.ctl.key_count = keys_ff;
                  hash_in = '0;
                  ended_in = 1'b0;
               end
            end
            CMD_REMOVE: begin
               if (keys_ff != 20'd0) begin
                  keys_in = keys_ff - 20'd1;
               end
               push = 1'b1;
               push_entry.ctl.key_count = keys_in;
            end
            CMD_INSERT: begin
               keys_in = keys_inc;
               push = 1'b1;
               push_entry.ctl.key_count = keys_inc;
               if (grow) begin
                  push_entry.ctl.split_now = 1'b1;
                  push_entry.ctl.split_from = sp_ff;
                  push_entry.ctl.split_to = new_addr[15:0];
                  push_entry.ctl.split_mask = 16'((32'(tsize_ff) << 1) - 32'd1);
                  if ((32'(new_addr) % BUCKETS_PER_SEGMENT) == 0 && segs_ff < SEG_MAX) begin
                     segs_in = segs_ff + 12'd1;
                  end
                  if (sp_plus == tsize_ff) begin
                     tsize_in = tsize_ff << 1;
                     sp_in = '0;
                  end else begin
                     sp_in = sp_plus[14:0];
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hash_ff <= '0;
         ended_ff <= 1'b0;
         sp_ff <= '0;
         tsize_ff <= 17'(BUCKETS_PER_SEGMENT);
         keys_ff <= '0;
         segs_ff <= 12'd1;
      end else begin
         hash_ff <= hash_in;
         ended_ff <= ended_in;
         sp_ff <= sp_in;
         tsize_ff <= tsize_in;
         keys_ff <= keys_in;
         segs_ff <= segs_in;
      end
   end

endmodule

@@ design/lhba_queue.sv @@
module lhba_queue import lhba_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_entry,
   input  logic      pop,
   output entry_type head_entry,
   output qstat_type q_stat
);

   localparam int PtrW = $clog2(QUEUE_DEPTH);
   localparam int CntW = $clog2(QUEUE_DEPTH + 1);

   entry_type           slots_ff [QUEUE_DEPTH];
   logic [PtrW-1:0]     wr_ff, wr_in;
   logic [PtrW-1:0]     rd_ff, rd_in;
   logic [CntW-1:0]     cnt_ff, cnt_in;
   logic                do_push;
   logic                do_pop;

   assign q_stat.empty = (cnt_ff == '0);
   assign q_stat.full = (cnt_ff == CntW'(QUEUE_DEPTH));
   assign do_push = push && !q_stat.full;
   assign do_pop = pop && !q_stat.empty;
   assign head_entry = slots_ff[rd_ff];

   always_comb begin
      wr_in = wr_ff;
      rd_in = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) begin
         wr_in = (wr_ff == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ff + PtrW'(1);
      end
      if (do_pop) begin
         rd_in = (rd_ff == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ff + PtrW'(1);
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + CntW'(1);
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ff] <= push_entry;
      end
   end

endmodule

@@ design/lhba_back.sv @@
module lhba_back import lhba_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  qstat_type   q_stat,
   input  entry_type   head_entry,
   output logic        pop,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_bucket,
   output logic [20:0] rsp_hash_value,
   output logic        rsp_split_now,
   output logic [14:0] rsp_split_from,
   output logic [15:0] rsp_split_to,
   output logic [15:0] rsp_split_mask,
   output logic [19:0] rsp_key_count
);

   logic        adv;
   logic        s1_v_ff, s2_v_ff, s3_v_ff, out_v_ff;
   ctl_type     s1_ctl_ff, s2_ctl_ff, s3_ctl_ff, out_ctl_ff;
   logic [25:0] s1_val_ff, s1_val_in;
   logic [21:0] s2_val_ff, s2_val_in;
   logic [20:0] s3_val_ff, s3_val_in;
   logic [15:0] bucket_ff, bucket_in;
   logic [20:0] hval_ff;
   logic [15:0] low_bucket;
   logic [26:0] fold;

   assign adv = !out_v_ff || !rsp_stall;
   assign pop = adv && !q_stat.empty;

   always_comb begin
      fold = 27'(head_entry.hash[19:0]) + 27'(head_entry.hash[59:40]) * RES_40 +
             27'(HASH_MOD) * 27'd8 - 27'(head_entry.hash[39:20]) * RES_20 -
             27'(head_entry.hash[63:60]) * RES_60;
      s1_val_in = fold[25:0];
      s2_val_in = 22'(s1_val_ff[19:0]) + 22'(HASH_MOD) - 22'(s1_val_ff[25:20]) * 22'd7;
      s3_val_in = (s2_val_ff >= 22'(HASH_MOD)) ? 21'(s2_val_ff - 22'(HASH_MOD))
                                              : s2_val_ff[20:0];
      low_bucket = s3_val_ff[15:0] & s3_ctl_ff.tmask;
      bucket_in = low_bucket;
      if (low_bucket < 16'(s3_ctl_ff.sp)) begin
         bucket_in = s3_val_ff[15:0] & {s3_ctl_ff.tmask[14:0], 1'b1};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
         out_v_ff <= 1'b0;
      end else if (adv) begin
         s1_v_ff <= pop;
         s2_v_ff <= s1_v_ff;
         s3_v_ff <= s2_v_ff;
         out_v_ff <= s3_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_ctl_ff <= head_entry.ctl;
         s1_val_ff <= s1_val_in;
         s2_ctl_ff <= s1_ctl_ff;
         s2_val_ff <= s2_val_in;
         s3_ctl_ff <= s2_ctl_ff;
         s3_val_ff <= s3_val_in;
         out_ctl_ff <= s3_ctl_ff;
         bucket_ff <= s3_ctl_ff.is_key ? bucket_in : '0;
         hval_ff <= s3_ctl_ff.is_key ? s3_val_ff : '0;
      end
   end

   assign rsp_valid = out_v_ff;
   assign rsp_bucket = bucket_ff;
   assign rsp_hash_value = hval_ff;
   assign rsp_split_now = out_ctl_ff.split_now;
   assign rsp_split_from = out_ctl_ff.split_from;
   assign rsp_split_to = out_ctl_ff.split_to;
   assign rsp_split_mask = out_ctl_ff.split_mask;
   assign rsp_key_count = out_ctl_ff.key_count;

endmodule

@@ design/linear_hash_bucket_addresser.sv @@
// Path: after its item transfers, a result passes through the queue, the stage
// registers s1, s2 and s3 and the output register; result stalls hold it there.
// Throughput: one item per cycle when not stalled, set by the front's running hash update.
// Reset is synchronous: the hash, split pointer and key count clear, the table size
// returns to 32 and the segment count to one, and the queue and pipeline empty.
module linear_hash_bucket_addresser import lhba_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_command,
   input  logic [7:0]  req_key_byte,
   input  logic        req_last,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_bucket,
   output logic [20:0] rsp_hash_value,
   output logic        rsp_split_now,
   output logic [14:0] rsp_split_from,
   output logic [15:0] rsp_split_to,
   output logic [15:0] rsp_split_mask,
   output logic [19:0] rsp_key_count
);

   qstat_type q_stat;
   logic      push;
   logic      pop;
   entry_type push_entry;
   entry_type head_entry;

   lhba_front u_front (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_command(req_command),
      .req_key_byte(req_key_byte),
      .req_last(req_last),
      .req_stall(req_stall),
      .q_stat(q_stat),
      .push(push),
      .push_entry(push_entry)
   );

   lhba_queue u_queue (
      .clock(clock),
      .reset(reset),
      .push(push),
      .push_entry(push_entry),
      .pop(pop),
      .head_entry(head_entry),
      .q_stat(q_stat)
   );

   lhba_back u_back (
      .clock(clock),
      .reset(reset),
      .q_stat(q_stat),
      .head_entry(head_entry),
      .pop(pop),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_bucket(rsp_bucket),
      .rsp_hash_value(rsp_hash_value),
      .rsp_split_now(rsp_split_now),
      .rsp_split_from(rsp_split_from),
      .rsp_split_to(rsp_split_to),
      .rsp_split_mask(rsp_split_mask),
      .rsp_key_count(rsp_key_count)
   );

   a_split_has_no_key : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_split_now |-> rsp_bucket == '0 && rsp_hash_value == '0 &&
                                     rsp_split_mask[0] && rsp_split_to <= rsp_split_mask)
      else $error("split result carries key fields or a bad mask");

   a_hash_reduced : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_hash_value < HASH_MOD)
      else $error("hash value not reduced");

   a_stall_needs_backlog : assert property (@(posedge clock) disable iff (reset)
      req_stall |-> !q_stat.empty)
      else $error("input stalled with an empty queue");

endmodule

@@ tb/tb.sv @@
module tb import lhba_pkg::*; ();

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam logic [63:0] HASH_MULT = 64'd37;

   typedef struct packed {
      logic [1:0] command;
      logic [7:0] key_byte;
      logic       last;
   } key_op_type;

   typedef struct packed {
      logic [15:0] bucket;
      logic [20:0] hash_value;
      logic        split_now;
      logic [14:0] split_from;
      logic [15:0] split_to;
      logic [15:0] split_mask;
      logic [19:0] key_count;
   } bucket_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_command = CMD_BYTE;
   logic [7:0]  req_key_byte = 8'd0;
   logic        req_last = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [15:0] rsp_bucket;
   logic [20:0] rsp_hash_value;
   logic        rsp_split_now;
   logic [14:0] rsp_split_from;
   logic [15:0] rsp_split_to;
   logic [15:0] rsp_split_mask;
   logic [19:0] rsp_key_count;

   key_op_type        pending_ops[$];
   bucket_result_type expected_buckets[$];
   key_op_type        next_op;

   int ops_sent = 0;
   int ops_taken = 0;
   int send_idle_pct = 0;
   int stall_pct = 0;
   logic hold_rsp = 1'b0;

   int error_count = 0;
   int results_seen = 0;
   int keys_hashed = 0;
   int splits_seen = 0;

   // Own copy of the addresser state.
   logic [63:0]     key_hash = 64'd0;
   bit              key_done = 1'b0;
   longint unsigned split_ptr = 0;
   longint unsigned table_buckets = BUCKETS_PER_SEGMENT;
   longint unsigned segment_total = 1;
   longint unsigned key_total = 0;

   linear_hash_bucket_addresser i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_command    (req_command),
      .req_key_byte   (req_key_byte),
      .req_last       (req_last),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_bucket     (rsp_bucket),
      .rsp_hash_value (rsp_hash_value),
      .rsp_split_now  (rsp_split_now),
      .rsp_split_from (rsp_split_from),
      .rsp_split_to   (rsp_split_to),
      .rsp_split_mask (rsp_split_mask),
      .rsp_key_count  (rsp_key_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic void predict_bucket(input logic [1:0] cmd, input logic [7:0] kb,
                                          input logic lst);
      bucket_result_type res;
      logic [63:0]       folded;
      longint unsigned   h;
      longint unsigned   b;
      longint unsigned   new_addr;
      res = '0;
      if (cmd == CMD_UNUSED) return;
      if (cmd == CMD_BYTE) begin
         if (kb == 8'd0) begin
            key_done = 1'b1;
         end else if (!key_done) begin
            folded = {56'd0, kb};
            if (kb >= CHAR_LOWER_A && kb <= CHAR_LOWER_Z) folded = folded - CASE_OFFSET;
            key_hash = (key_hash * HASH_MULT) ^ folded;
         end
         if (!lst) return;
         h = key_hash % HASH_MOD;
         b = h % table_buckets;
         if (b < split_ptr) b = h % (table_buckets * 2);
         res.bucket = 16'(b);
         res.hash_value = 21'(h);
         key_hash = 64'd0;
         key_done = 1'b0;
      end else if (cmd == CMD_REMOVE) begin
         if (key_total > 0) key_total--;
      end else begin
         if (key_total < COUNT_MAX) key_total++;
         if (key_total >= segment_total * BUCKETS_PER_SEGMENT &&
             table_buckets + split_ptr < MAX_BUCKETS) begin
            new_addr = table_buckets + split_ptr;
            res.split_now = 1'b1;
            res.split_from = 15'(split_ptr);
            res.split_to = 16'(new_addr);
            res.split_mask = 16'(table_buckets * 2 - 1);
            if (new_addr % BUCKETS_PER_SEGMENT == 0 && segment_total < SEG_MAX)
               segment_total++;
            split_ptr++;
            if (split_ptr == table_buckets) begin
               table_buckets = table_buckets * 2;
               split_ptr = 0;
            end
         end
      end
      res.key_count = 20'(key_total);
      expected_buckets.push_back(res);
   endfunction

   task automatic report_mismatch(input string msg);
      $display("MISMATCH at result %0d: %s", results_seen, msg);
      error_count++;
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
   endtask

   task automatic check_result();
      bucket_result_type want;
      if (expected_buckets.size() == 0) begin
         report_mismatch("result arrived with nothing expected");
      end else begin
         want = expected_buckets.pop_front();
         check_field("bucket", rsp_bucket, want.bucket);
         check_field("hash_value", rsp_hash_value, want.hash_value);
         check_field("split_now", rsp_split_now, want.split_now);
         check_field("split_from", rsp_split_from, want.split_from);
         check_field("split_to", rsp_split_to, want.split_to);
         check_field("split_mask", rsp_split_mask, want.split_mask);
         check_field("key_count", rsp_key_count, want.key_count);
         if (want.split_now) splits_seen++;
         if (want.hash_value != 0 || want.bucket != 0) keys_hashed++;
      end
      results_seen++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            predict_bucket(req_command, req_key_byte, req_last);
            ops_taken++;
         end
         if (!req_valid || !req_stall) begin
            if (pending_ops.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               next_op = pending_ops.pop_front();
               req_valid <= 1'b1;
               req_command <= next_op.command;
               req_key_byte <= next_op.key_byte;
               req_last <= next_op.last;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) check_result();
         rsp_stall <= hold_rsp || ($urandom_range(99) < stall_pct);
      end
   end

   task automatic send_op(input logic [1:0] cmd, input logic [7:0] kb, input logic lst);
      key_op_type op;
      op.command = cmd;
      op.key_byte = kb;
      op.last = lst;
      pending_ops.push_back(op);
      ops_sent++;
   endtask

   task automatic send_key();
      int len;
      int r;
      logic [7:0] kb;
      len = ($urandom_range(9) == 0) ? $urandom_range(13, 24) : $urandom_range(0, 8);
      if (len == 0) begin
         send_op(CMD_BYTE, 8'd0, 1'b1);
      end else begin
         for (int k = 0; k < len; k++) begin
            r = $urandom_range(99);
            if (r < 40) kb = 8'($urandom_range(8'h61, 8'h7A));
            else if (r < 60) kb = 8'($urandom_range(8'h41, 8'h5A));
            else if (r < 96) kb = 8'($urandom_range(1, 255));
            else kb = 8'd0;
            send_op(CMD_BYTE, kb, k == len - 1);
         end
      end
   endtask

   task automatic send_sequence();
      int r;
      int n;
      r = $urandom_range(99);
      if (r < 70) begin
         send_key();
         n = $urandom_range(99);
         if (n < 65) send_op(CMD_INSERT, 8'($urandom), 1'($urandom));
         else if (n < 85) send_op(CMD_REMOVE, 8'($urandom), 1'($urandom));
      end else if (r < 82) begin
         n = $urandom_range(1, 24);
         repeat (n) send_op(CMD_INSERT, 8'($urandom), 1'($urandom));
      end else if (r < 87) begin
         n = $urandom_range(1, 8);
         repeat (n) send_op(CMD_REMOVE, 8'($urandom), 1'($urandom));
      end else if (r < 95) begin
         send_op(2'($urandom_range(0, 3)), 8'($urandom), 1'($urandom));
      end else begin
         send_op(CMD_UNUSED, 8'($urandom), 1'($urandom));
      end
   endtask

   task automatic run_phase(input int idle, input int stall, input int count);
      int start;
      @(negedge clock);
      send_idle_pct = idle;
      stall_pct = stall;
      start = ops_sent;
      while (ops_sent < start + count) send_sequence();
      while (pending_ops.size() != 0) @(negedge clock);
   endtask

   task automatic wait_drained();
      while (ops_taken != ops_sent || expected_buckets.size() != 0) @(negedge clock);
   endtask

   initial begin
      wait (ops_taken >= 150);
      @(negedge clock);
      hold_rsp = 1'b1;
      repeat (300) @(negedge clock);
      hold_rsp = 1'b0;
   end

   initial begin
      #(64'd60_000_000);
      $display("[linear_hash_bucket_addresser] ERROR");
      $finish;
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      send_op(CMD_REMOVE, 8'h00, 1'b0);
      send_op(CMD_BYTE, 8'h00, 1'b1);
      send_op(CMD_BYTE, 8'h61, 1'b1);
      send_op(CMD_BYTE, 8'h41, 1'b1);
      send_op(CMD_BYTE, 8'h60, 1'b0);
      send_op(CMD_BYTE, 8'h7A, 1'b0);
      send_op(CMD_BYTE, 8'h7B, 1'b1);
      send_op(CMD_BYTE, 8'h41, 1'b0);
      send_op(CMD_BYTE, 8'h00, 1'b0);
      send_op(CMD_BYTE, 8'h42, 1'b1);
      send_op(CMD_UNUSED, 8'hFF, 1'b1);
      send_op(CMD_INSERT, 8'hFF, 1'b1);
      send_op(CMD_INSERT, 8'h00, 1'b0);
      send_op(CMD_REMOVE, 8'hFF, 1'b1);
      send_op(CMD_BYTE, 8'hFF, 1'b0);
      send_op(CMD_BYTE, 8'h80, 1'b1);
      wait_drained();

      run_phase(0, 0, 375);
      run_phase(57, 0, 375);
      wait_drained();
      run_phase(0, 57, 375);
      run_phase(9, 9, 375);
      wait_drained();
      repeat (20) @(negedge clock);

      $display("Checked %0d results: %0d nonzero key addresses, %0d splits,",
               results_seen, keys_hashed, splits_seen);
      $display("table at %0d buckets, over full rate, sender gaps, receiver stalls,",
               table_buckets);
      $display("both at once, and a long hold-off of the result side.");
      if (error_count == 0) begin
         $display("[linear_hash_bucket_addresser] OK");
      end else begin
         $display("[linear_hash_bucket_addresser] ERROR");
      end
      $finish;
   end

endmodule
